@@ hw/rtl/md5_pkg.sv @@
package md5_pkg;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C = 32'h98BADCFE;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
    localparam logic [7:0] PAD_ZERO_BYTE = 8'h00;

    localparam logic [5:0] LEN_START_POS = 6'd56;
    localparam logic [5:0] LAST_POS      = 6'd63;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [1:0] LAST_WORD_NUM = 2'd3;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_AMOUNT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    typedef struct packed {
        logic       en;
        logic [5:0] pos;
        logic [7:0] data;
    } buf_wr_t;

    // message word index used by a given round
    function automatic logic [3:0] word_index(input logic [5:0] rnd);
        logic [3:0] i;
        begin
            i = rnd[3:0];
            case (rnd[5:4])
                2'd0:    word_index = i;
                2'd1:    word_index = 4'(i * 4'd5 + 4'd1);
                2'd2:    word_index = 4'(i * 4'd3 + 4'd5);
                2'd3:    word_index = 4'(i * 4'd7);
                default: word_index = i;
            endcase
        end
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        begin
            t = {x, x} << s;
            rotl32 = t[63:32];
        end
    endfunction

endpackage

@@ hw/rtl/md5_blkbuf.sv @@
module md5_blkbuf (
    input  logic               clk,
    input  md5_pkg::buf_wr_t   wr,
    input  logic [3:0]         rd_idx,
    output logic [31:0]        rd_word
);

    logic [31:0] word_reg [16];

    // byte lanes fill little-endian; all four lanes are written before a read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            word_reg[wr.pos[5:2]][{wr.pos[1:0], 3'b000} +: 8] <= wr.data;
        end
    end

    assign rd_word = word_reg[rd_idx];

endmodule

@@ hw/rtl/md5_round.sv @@
module md5_round (
    input  logic [5:0]  rnd,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] kw,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;

    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (d & b) | (~d & c);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
    end

    // kw already holds round constant plus message word
    assign sum   = a + f + kw;
    assign b_new = b + md5_pkg::rotl32(sum, md5_pkg::ROT_AMOUNT[{rnd[5:4], rnd[1:0]}]);

endmodule

@@ hw/rtl/md5_message_digest.sv @@
// MD5 digest over a byte stream.
// Input channel (in_valid/in_ready): each request carries data_byte, byte_present
// and end_of_message. A request with byte_present low and end_of_message low
// is absorbed with no effect.
// Output channel (out_valid/out_ready): after an end_of_message request the
// block returns four requests, digest words A to D (word_number 0 to 3,
// last_word on D), then starts a fresh message.
// Operation: each accepted byte is written into the block buffer; every 64th
// byte also runs the block compression (load, 64 rounds on the single round
// unit, chaining add), during which no new byte is taken.
// Finishing a message writes padding one byte per cycle, paused while a block
// compresses, plus one or two compressions, then the four digest words.
// in_ready is high only while the block waits for input; it stays low during
// compression, padding and digest output.
// A stalled receiver holds the current digest word; the block waits for it.
// Reset loads the MD5 initial chaining values and clears the byte and bit
// counters; no clearing pass is needed.
module md5_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [1:0]  word_number,
    output logic        last_word
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PAD_MARK = 7'b0000010,
        S_PAD_ZERO = 7'b0000100,
        S_PAD_LEN  = 7'b0001000,
        S_LOAD     = 7'b0010000,
        S_ROUND    = 7'b0100000,
        S_ADD      = 7'b1000000
    } ctl_state_t;

    ctl_state_t  state_reg, state_next;
    ctl_state_t  ret_reg, ret_next;
    logic        emit_reg, emit_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] count_reg, count_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [1:0]  wnum_reg, wnum_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];

    logic [31:0] a_reg, b_reg, c_reg, d_reg, kw_reg;
    logic [31:0] b_new;
    logic [31:0] rd_word;
    logic [5:0]  rnd_ahead;
    md5_pkg::buf_wr_t wr;

    logic in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    assign in_ready    = (state_reg == S_IDLE) && !emit_reg;
    assign out_valid   = emit_reg && (state_reg == S_IDLE);
    assign digest_word = chain_reg[wnum_reg];
    assign word_number = wnum_reg;
    assign last_word   = (wnum_reg == md5_pkg::LAST_WORD_NUM);

    assign rnd_ahead = (state_reg == S_LOAD) ? 6'd0 : 6'(rnd_reg + 6'd1);

    md5_blkbuf u_blkbuf (
        .clk     (clk),
        .wr      (wr),
        .rd_idx  (md5_pkg::word_index(rnd_ahead)),
        .rd_word (rd_word)
    );

    md5_round u_round (
        .rnd   (rnd_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (c_reg),
        .d     (d_reg),
        .kw    (kw_reg),
        .b_new (b_new)
    );

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        emit_next  = emit_reg;
        fill_next  = fill_reg;
        count_next = count_reg;
        rnd_next   = rnd_reg;
        wnum_next  = wnum_reg;
        chain_next = chain_reg;
        wr.en      = 1'b0;
        wr.pos     = fill_reg;
        wr.data    = data_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (emit_reg)
                begin
                    if (out_acc)
                    begin
                        wnum_next = 2'(wnum_reg + 2'd1);
                        if (wnum_reg == md5_pkg::LAST_WORD_NUM)
                        begin
                            emit_next     = 1'b0;
                            chain_next[0] = md5_pkg::INIT_A;
                            chain_next[1] = md5_pkg::INIT_B;
                            chain_next[2] = md5_pkg::INIT_C;
                            chain_next[3] = md5_pkg::INIT_D;
                            count_next    = '0;
                            fill_next     = '0;
                        end
                    end
                end
                else if (in_acc)
                begin
                    if (byte_present)
                    begin
                        wr.en      = 1'b1;
                        fill_next  = 6'(fill_reg + 6'd1);
                        count_next = count_reg + md5_pkg::BITS_PER_BYTE;
                    end
                    if (byte_present && fill_reg == md5_pkg::LAST_POS)
                    begin
                        ret_next   = end_of_message ? S_PAD_MARK : S_IDLE;
                        state_next = S_LOAD;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD_MARK;
                    end
                end
            end
            S_PAD_MARK:
            begin
                wr.en     = 1'b1;
                wr.data   = md5_pkg::PAD_MARK_BYTE;
                fill_next = 6'(fill_reg + 6'd1);
                if (fill_reg == md5_pkg::LAST_POS)
                begin
                    ret_next   = S_PAD_ZERO;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_PAD_ZERO;
                end
            end
            S_PAD_ZERO:
            begin
                if (fill_reg == md5_pkg::LEN_START_POS)
                begin
                    state_next = S_PAD_LEN;
                end
                else
                begin
                    wr.en     = 1'b1;
                    wr.data   = md5_pkg::PAD_ZERO_BYTE;
                    fill_next = 6'(fill_reg + 6'd1);
                    if (fill_reg == md5_pkg::LAST_POS)
                    begin
                        ret_next   = S_PAD_ZERO;
                        state_next = S_LOAD;
                    end
                end
            end
            S_PAD_LEN:
            begin
                // bit count goes out little-endian in the last eight slots
                wr.en     = 1'b1;
                wr.data   = count_reg[{fill_reg[2:0], 3'b000} +: 8];
                fill_next = 6'(fill_reg + 6'd1);
                if (fill_reg == md5_pkg::LAST_POS)
                begin
                    ret_next   = S_IDLE;
                    emit_next  = 1'b1;
                    wnum_next  = '0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                rnd_next   = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                rnd_next = rnd_ahead;
                if (rnd_reg == md5_pkg::LAST_ROUND)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                state_next    = ret_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            emit_reg     <= 1'b0;
            fill_reg     <= '0;
            count_reg    <= '0;
            rnd_reg      <= '0;
            wnum_reg     <= '0;
            chain_reg[0] <= md5_pkg::INIT_A;
            chain_reg[1] <= md5_pkg::INIT_B;
            chain_reg[2] <= md5_pkg::INIT_C;
            chain_reg[3] <= md5_pkg::INIT_D;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            emit_reg  <= emit_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            rnd_reg   <= rnd_next;
            wnum_reg  <= wnum_next;
            chain_reg <= chain_next;
        end
    end

    // working variables and the next round's constant plus message word
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
        begin
            a_reg  <= chain_reg[0];
            b_reg  <= chain_reg[1];
            c_reg  <= chain_reg[2];
            d_reg  <= chain_reg[3];
            kw_reg <= md5_pkg::ROUND_CONST[rnd_ahead] + rd_word;
        end
        else if (state_reg == S_ROUND)
        begin
            a_reg  <= d_reg;
            b_reg  <= b_new;
            c_reg  <= b_reg;
            d_reg  <= c_reg;
            kw_reg <= md5_pkg::ROUND_CONST[rnd_ahead] + rd_word;
        end
    end

endmodule

@@ tb/sv/tb_md5_message_digest.sv @@
`timescale 1ns / 100ps

module tb_md5_message_digest;

    localparam int          CYCLE_LIMIT = 400000;
    localparam int          DRAIN_CYCLES = 200;
    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hEFCDAB89;
    localparam logic [31:0] IV_C = 32'h98BADCFE;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_FIRST = 8'h80;
    localparam logic [5:0]  LENGTH_SLOT = 6'd56;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int MD5_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct {
        logic [31:0] word;
        logic [1:0]  num;
        logic        last;
    } digest_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        last_word;

    // predictor state
    logic [31:0] chain_words [4];
    logic [31:0] block_buf [16];
    logic [63:0] bit_total;
    logic [5:0]  fill_slot;

    digest_rec_t digest_q [$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          message_items = 0;

    md5_message_digest u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_number    (word_number),
        .last_word      (last_word)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rotl_word(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void start_message();
        chain_words[0] = IV_A;
        chain_words[1] = IV_B;
        chain_words[2] = IV_C;
        chain_words[3] = IV_D;
        bit_total = '0;
        fill_slot = '0;
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, tmp;
        int          g;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (int i = 0; i < 64; i++)
        begin
            case (i / 16)
                0:
                begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1:
                begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2:
                begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default:
                begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            tmp = d;
            d = c;
            c = b;
            b = b + rotl_word(a + f + MD5_K[i] + block_buf[g], MD5_SHIFT[(i / 16) * 4 + i % 4]);
            a = tmp;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        if (fill_slot[1:0] == 2'd0)
            block_buf[fill_slot[5:2]] = {24'h0, b};
        else
            block_buf[fill_slot[5:2]][fill_slot[1:0] * 8 +: 8] = b;
        fill_slot = fill_slot + 6'd1;
        if (fill_slot == 6'd0)
            md5_compress();
    endfunction

    function automatic void predict_digest(input logic [7:0] b, input logic p, input logic e);
        logic [63:0] length_bits;
        digest_rec_t rec;
        if (p)
        begin
            bit_total = bit_total + 64'd8;
            absorb_byte(b);
        end
        if (e)
        begin
            length_bits = bit_total;
            absorb_byte(PAD_FIRST);
            while (fill_slot != LENGTH_SLOT)
                absorb_byte(8'h00);
            for (int k = 0; k < 8; k++)
                absorb_byte(length_bits[8 * k +: 8]);
            for (int k = 0; k < 4; k++)
            begin
                rec.word = chain_words[k];
                rec.num = 2'(k);
                rec.last = (k == 3);
                digest_q.push_back(rec);
            end
            start_message();
        end
    endfunction

    // sender: bursts of random length with random gaps between them
    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                data_byte = 8'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        @(negedge clk);
        in_valid = 1'b1;
        data_byte = b;
        byte_present = p;
        end_of_message = e;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
        if (p || e)
            message_items++;
        predict_digest(b, p, e);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (digest_q.size() != 0)
            @(posedge clk);
    endtask

    // random content, optional absent-byte requests, last byte either on the end request
    // or followed by an empty end request
    task automatic send_message(input int len, input bit noisy);
        bit byte_on_end;
        byte_on_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int k = 0; k < len; k++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            if (k == len - 1 && byte_on_end)
                send_item(8'($urandom), 1'b1, 1'b1);
            else
                send_item(8'($urandom), 1'b1, 1'b0);
        end
        if (!byte_on_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_item(8'hff, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_short_messages();
        send_item("a", 1'b1, 1'b0);
        send_item("b", 1'b1, 1'b0);
        send_item("c", 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_absent_bytes();
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7f, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hfe, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_padding_boundaries();
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        wait_drained();
        send_message(64, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int len;
        message_items = 0;
        while (message_items < 100)
        begin
            if ($urandom_range(0, 3) == 0)
                len = $urandom_range(17, 70);
            else
                len = $urandom_range(0, 16);
            send_message(len, 1'b1);
            if ($urandom_range(0, 4) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    // receiver stall pattern rotates among four modes: always ready, random, sparse, mostly ready
    always @(negedge clk)
    begin
        case ((cycle_count / 150) % 4)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            2:       out_ready <= (cycle_count % 5 == 0);
            default: out_ready <= ($urandom_range(0, 4) != 0);
        endcase
    end

    always @(posedge clk)
    begin
        digest_rec_t exp_rec;
        if (rst_n && out_valid && out_ready)
        begin
            if (digest_q.size() == 0)
            begin
                $display("%0t: unexpected digest word %h num %0d last %0b", $time,
                         digest_word, word_number, last_word);
                error_count++;
            end
            else
            begin
                exp_rec = digest_q.pop_front();
                if (digest_word !== exp_rec.word)
                begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             exp_rec.word, digest_word);
                    error_count++;
                end
                if (word_number !== exp_rec.num)
                begin
                    $display("%0t: word_number expected %0d actual %0d", $time,
                             exp_rec.num, word_number);
                    error_count++;
                end
                if (last_word !== exp_rec.last)
                begin
                    $display("%0t: last_word expected %0b actual %0b", $time,
                             exp_rec.last, last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[md5_message_digest] ERROR");
            $finish;
        end
    end

    initial
    begin
        for (int k = 0; k < 16; k++)
            block_buf[k] = '0;
        start_message();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_message();
        test_short_messages();
        test_absent_bytes();
        test_padding_boundaries();
        test_random_messages();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && digest_q.size() == 0)
            $display("[md5_message_digest] OK");
        else
            $display("[md5_message_digest] ERROR");
        $finish;
    end

endmodule
